>>> sv/msplit_pkg.sv
// Shared types, constants and helpers for the Matroska segment splitter.
// No dependencies.
package msplit_pkg;

	localparam int WINDOW = 65536;
	localparam int ADDR_W = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int AGE_W  = $clog2(WINDOW) + 1;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	localparam logic [31:0] SEG_ID = 32'h1853_8067;
	localparam logic [31:0] LEVEL1_IDS [7] = '{
		32'h1549_A966, 32'h1654_AE6B, 32'h114D_9B74, 32'h1C53_BB6B,
		32'h1941_A469, 32'h1043_A770, 32'h1254_C367
	};
	localparam logic [7:0] EBML_HDR [16] = '{
		8'h1A, 8'h45, 8'hDF, 8'hA3, 8'h8B, 8'h42, 8'h82, 8'h88,
		8'h6D, 8'h61, 8'h74, 8'h72, 8'h6F, 8'h73, 8'h6B, 8'h61
	};

	typedef struct packed {
		logic [7:0] data;
		logic       cand;
		logic       age_ok;
		logic       drained;
	} rec_t;

	typedef enum logic [1:0] {
		PH_DECIDE,
		PH_HDR,
		PH_BYTE
	} phase_t;

	function automatic logic [ADDR_W-1:0] addr_add(input logic [ADDR_W-1:0] a,
		input logic [ADDR_W:0] k);
		logic [ADDR_W:0] s;
		s = {1'b0, a} + k;
		if (s >= (ADDR_W+1)'(WINDOW))
			s = s - (ADDR_W+1)'(WINDOW);
		return s[ADDR_W-1:0];
	endfunction

endpackage

>>> sv/matroska_segment_splitter.sv
// Top level of the Matroska segment splitter.
// Depends on msplit_pkg, msplit_front, msplit_queue and msplit_back.

// Bytes (cmd 0) and drain steps (cmd 1) enter through a queue-style port at
// one transaction per cycle while full is low. Each byte passes through a
// 65536-entry delay line held in one memory with a write port and two read
// ports; a leaving byte is read into a stage register, crosses a 4-entry
// record queue and is judged on its way into the result register. Results
// leave at one per cycle while pop is held: an ordinary byte gives one
// result, a segment start the 16 EBML header bytes, then the ID byte; during
// such a burst full rises once the record queue fills. Bytes before the first
// valid segment produce no result. No clearing pass is needed after reset.
module matroska_segment_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [7:0]  in_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        is_header,
	output logic        segment_start,
	output logic [15:0] segment_number,
	output logic        last_in_run,
	output logic        drained
);
	import msplit_pkg::*;

	logic              q_wr, q_rd, q_nempty;
	rec_t              q_wr_rec, q_rd_rec;
	logic [QLVL_W-1:0] q_level;

	msplit_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.cmd     (cmd),
		.in_byte (in_byte),
		.q_level (q_level),
		.q_wr    (q_wr),
		.q_rec   (q_wr_rec)
	);

	msplit_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_rec (q_wr_rec),
		.rd     (q_rd),
		.nempty (q_nempty),
		.rd_rec (q_rd_rec),
		.level  (q_level)
	);

	msplit_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_v          (q_nempty),
		.rec            (q_rd_rec),
		.rec_rd         (q_rd),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.is_header      (is_header),
		.segment_start  (segment_start),
		.segment_number (segment_number),
		.last_in_run    (last_in_run),
		.drained        (drained)
	);

	a_qlevel: assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= QLVL_W'(QDEPTH))
		else $error("record queue overflow");

	a_start_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && segment_start) |-> (is_header && !last_in_run))
		else $error("segment start outside header");

	a_byte_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_header) |-> (last_in_run && segment_number != 16'd0))
		else $error("stream byte not last or outside segment");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_level == QLVL_W'(QDEPTH)) |-> !q_wr)
		else $error("queue write beyond depth");

endmodule

>>> sv/msplit_front.sv
// Front end: accepts bytes and drain steps, holds the delay line memory,
// tracks level-1 IDs and issues one judged record per leaving byte. Uses msplit_pkg.
module msplit_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     cmd,
	input  logic [7:0]               in_byte,
	input  logic [msplit_pkg::QLVL_W-1:0] q_level,
	output logic                     q_wr,
	output msplit_pkg::rec_t         q_rec
);
	import msplit_pkg::*;

	logic [8:0]        mem [WINDOW];
	logic [ADDR_W-1:0] head_q, tail_q;
	logic [FILL_W-1:0] fill_q, fill_d, fill_pop;
	logic [23:0]       hist_q;
	logic [AGE_W-1:0]  age_q, age_d;
	logic [31:0]       w;
	logic              hit, acc, do_push, pop_now, age_ok, ge4, drn;
	logic              v_s1, ge4_s1, age_ok_s1, drained_s1;
	logic [8:0]        rd0_s1, rd3_s1;

	assign full = ({1'b0, q_level} + (QLVL_W+1)'(v_s1)) >= (QLVL_W+1)'(QDEPTH);

	always_comb begin
		acc     = push && !full;
		do_push = acc && !cmd;
		w       = {hist_q, in_byte};
		hit     = 1'b0;
		for (int i = 0; i < 7; i++)
			if (w == LEVEL1_IDS[i])
				hit = 1'b1;
		pop_now  = acc && (cmd ? (fill_q != '0) : (fill_q == FILL_W'(WINDOW - 1)));
		fill_pop = cmd ? fill_q : FILL_W'(WINDOW);
		if (do_push)
			age_d = hit ? AGE_W'(3) : ((age_q == '1) ? age_q : age_q + AGE_W'(1));
		else
			age_d = age_q;
		age_ok = (AGE_W+1)'(age_d) <= ((AGE_W+1)'(fill_pop) - (AGE_W+1)'(1));
		ge4    = fill_pop >= FILL_W'(4);
		drn    = cmd && (fill_q == FILL_W'(1));
		if (do_push && !pop_now)
			fill_d = fill_q + FILL_W'(1);
		else if (cmd && pop_now)
			fill_d = fill_q - FILL_W'(1);
		else
			fill_d = fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			hist_q <= '0;
			age_q  <= '1;
			v_s1   <= 1'b0;
		end else begin
			fill_q <= fill_d;
			age_q  <= age_d;
			v_s1   <= pop_now;
			if (do_push) begin
				hist_q <= w[23:0];
				tail_q <= addr_add(tail_q, (ADDR_W+1)'(1));
			end
			if (pop_now)
				head_q <= addr_add(head_q, (ADDR_W+1)'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem[tail_q] <= {w == SEG_ID, in_byte};
		if (pop_now) begin
			rd0_s1     <= mem[head_q];
			rd3_s1     <= mem[addr_add(head_q, (ADDR_W+1)'(3))];
			ge4_s1     <= ge4;
			age_ok_s1  <= age_ok;
			drained_s1 <= drn;
		end
	end

	assign q_wr          = v_s1;
	assign q_rec.data    = rd0_s1[7:0];
	assign q_rec.cand    = rd3_s1[8] && ge4_s1;
	assign q_rec.age_ok  = age_ok_s1;
	assign q_rec.drained = drained_s1;

endmodule

>>> sv/msplit_queue.sv
// Short record queue between the front and back ends.
// Uses msplit_pkg.
module msplit_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr,
	input  msplit_pkg::rec_t              wr_rec,
	input  logic                          rd,
	output logic                          nempty,
	output msplit_pkg::rec_t              rd_rec,
	output logic [msplit_pkg::QLVL_W-1:0] level
);
	import msplit_pkg::*;

	rec_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QLVL_W-1:0] cnt_q;
	logic              do_rd;

	assign nempty = cnt_q != '0;
	assign level  = cnt_q;
	assign rd_rec = slot_q[rp_q];
	assign do_rd  = rd && nempty;

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wp_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + QPTR_W'(1);
			if (do_rd)
				rp_q <= rp_q + QPTR_W'(1);
			if (wr && !do_rd)
				cnt_q <= cnt_q + QLVL_W'(1);
			else if (do_rd && !wr)
				cnt_q <= cnt_q - QLVL_W'(1);
		end
	end

endmodule

>>> sv/msplit_back.sv
// Back end: judges segment candidates, injects EBML headers and holds the
// result register. Uses msplit_pkg.
module msplit_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rec_v,
	input  msplit_pkg::rec_t rec,
	output logic             rec_rd,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       out_byte,
	output logic             is_header,
	output logic             segment_start,
	output logic [15:0]      segment_number,
	output logic             last_in_run,
	output logic             drained
);
	import msplit_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  idx_q;
	logic [15:0] seg_q, seg_inc;
	logic [1:0]  skip_q;
	logic        in_seg_q, out_v_q, ld_ok, go, valid_seg, cand;
	logic        emit, e_hdr, e_start, e_last;
	logic [7:0]  e_byte;

	assign ld_ok     = !out_v_q || pop;
	assign go        = rec_v && ld_ok;
	assign cand      = (skip_q == 2'd0) && rec.cand;
	assign valid_seg = cand && rec.age_ok;
	assign seg_inc   = (seg_q == 16'hFFFF) ? seg_q : seg_q + 16'd1;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_DECIDE: if (go && valid_seg) phase_d = PH_HDR;
			PH_HDR:    if (go && idx_q == 4'd15) phase_d = PH_BYTE;
			PH_BYTE:   if (go) phase_d = PH_DECIDE;
			default:   phase_d = PH_DECIDE;
		endcase
	end

	always_comb begin
		emit    = 1'b0;
		e_hdr   = 1'b0;
		e_start = 1'b0;
		e_last  = 1'b0;
		e_byte  = rec.data;
		rec_rd  = 1'b0;
		case (phase_q)
			PH_DECIDE: begin
				if (go) begin
					if (valid_seg) begin
						emit    = 1'b1;
						e_hdr   = 1'b1;
						e_start = 1'b1;
						e_byte  = EBML_HDR[0];
					end else begin
						emit   = in_seg_q;
						e_last = 1'b1;
						rec_rd = 1'b1;
					end
				end
			end
			PH_HDR: begin
				emit   = go;
				e_hdr  = 1'b1;
				e_byte = EBML_HDR[idx_q];
			end
			PH_BYTE: begin
				emit   = go;
				e_last = 1'b1;
				rec_rd = go;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DECIDE;
			idx_q    <= '0;
			seg_q    <= '0;
			skip_q   <= '0;
			in_seg_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (go && phase_q == PH_DECIDE) begin
				if (skip_q != 2'd0)
					skip_q <= skip_q - 2'd1;
				else if (rec.cand)
					skip_q <= 2'd3;
				if (valid_seg) begin
					seg_q    <= seg_inc;
					in_seg_q <= 1'b1;
					idx_q    <= 4'd1;
				end
			end else if (go && phase_q == PH_HDR) begin
				idx_q <= idx_q + 4'd1;
			end
			if (emit)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte       <= e_byte;
			is_header      <= e_hdr;
			segment_start  <= e_start;
			segment_number <= (phase_q == PH_DECIDE && valid_seg) ? seg_inc : seg_q;
			last_in_run    <= e_last;
			drained        <= rec.drained;
		end
	end

	assign empty = !out_v_q;

endmodule

>>> sim/matroska_segment_splitter_tb.sv
// Testbench for matroska_segment_splitter: directed and random byte streams
// are checked result by result against a behavioral predictor of the splitter.
// Depends on msplit_pkg and the matroska_segment_splitter RTL.
`timescale 1ns / 1ps

module matroska_segment_splitter_tb;
	import msplit_pkg::*;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;
	localparam int   STALL_LIMIT = 5000;
	localparam int unsigned AGE_NONE = 32'hFFFF_FFFF;

	typedef struct {
		logic [7:0]  data;
		logic        hdr;
		logic        start;
		logic [15:0] num;
		logic        last;
		logic        drn;
	} seg_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        cmd = CMD_BYTE;
	logic [7:0]  in_byte = 8'h00;
	logic        pop = 1'b0;
	logic        full, empty;
	logic [7:0]  out_byte;
	logic        is_header, segment_start, last_in_run, drained;
	logic [15:0] segment_number;

	seg_byte_t   seg_bytes_due[$];
	logic [7:0]  line_mem [WINDOW];
	int unsigned line_head, line_fill, id_history, l1_age, seg_count, id_skip;
	bit          seg_open;
	int          send_idle_pct, pop_stall_pct, items_sent, idle_cycles;
	bit          failed;

	matroska_segment_splitter u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.in_byte(in_byte), .empty(empty), .pop(pop), .out_byte(out_byte),
		.is_header(is_header), .segment_start(segment_start),
		.segment_number(segment_number), .last_in_run(last_in_run), .drained(drained)
	);

	always #10 clk = ~clk;

	function automatic void emit_byte(ref seg_byte_t run[$], input logic [7:0] b,
		input logic hdr, input logic start);
		seg_byte_t r;
		r.data = b;
		r.hdr = hdr;
		r.start = start;
		r.num = seg_count[15:0];
		r.last = 1'b0;
		r.drn = 1'b0;
		run.push_back(r);
	endfunction

	function automatic void shift_in(input logic [7:0] b);
		logic [31:0] w;
		bit hit;
		w = {id_history[23:0], b};
		hit = 0;
		line_mem[(line_head + line_fill) % WINDOW] = b;
		line_fill++;
		id_history = w[23:0];
		foreach (LEVEL1_IDS[i])
			if (w == LEVEL1_IDS[i])
				hit = 1;
		if (hit)
			l1_age = 3;
		else if (l1_age != AGE_NONE)
			l1_age++;
	endfunction

	function automatic void judge_front(ref seg_byte_t run[$]);
		logic [7:0] b;
		logic [31:0] w;
		if (line_fill == 0)
			return;
		b = line_mem[line_head];
		if (id_skip > 0) begin
			id_skip--;
		end else if (line_fill >= 4) begin
			w = {b, line_mem[(line_head + 1) % WINDOW], line_mem[(line_head + 2) % WINDOW],
				line_mem[(line_head + 3) % WINDOW]};
			if (w == SEG_ID) begin
				id_skip = 3;
				if (l1_age <= line_fill - 1) begin
					if (seg_count < 16'hFFFF)
						seg_count++;
					seg_open = 1;
					for (int i = 0; i < 16; i++)
						emit_byte(run, EBML_HDR[i], 1'b1, i == 0);
				end
			end
		end
		if (seg_open)
			emit_byte(run, b, 1'b0, 1'b0);
		line_head = (line_head + 1) % WINDOW;
		line_fill--;
	endfunction

	function automatic void predict_split(input logic c, input logic [7:0] b);
		seg_byte_t run[$];
		if (c == CMD_DRAIN) begin
			judge_front(run);
		end else begin
			shift_in(b);
			if (line_fill >= WINDOW)
				judge_front(run);
		end
		if (run.size() > 0) begin
			run[run.size() - 1].last = 1'b1;
			if (c == CMD_DRAIN && line_fill == 0)
				foreach (run[k])
					run[k].drn = 1'b1;
		end
		foreach (run[k])
			seg_bytes_due.push_back(run[k]);
	endfunction

	task automatic send_item(input logic c, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		cmd = c;
		in_byte = b;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		predict_split(c, b);
		items_sent++;
	endtask

	task automatic send_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			send_item(CMD_BYTE, w[i*8 +: 8]);
	endtask

	task automatic drain_steps(input int n);
		repeat (n)
			send_item(CMD_DRAIN, 8'($urandom_range(255)));
	endtask

	task automatic drain_all();
		while (line_fill > 0)
			send_item(CMD_DRAIN, 8'($urandom_range(255)));
	endtask

	task automatic test_directed();
		send_item(CMD_DRAIN, 8'hFF);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, 8'hFF);
		send_word(SEG_ID);
		send_word(SEG_ID);
		send_word(LEVEL1_IDS[0]);
		send_item(CMD_BYTE, 8'h18);
		send_item(CMD_BYTE, 8'h53);
		send_item(CMD_BYTE, 8'h80);
		drain_all();
		send_item(CMD_DRAIN, 8'h00);
		send_word(SEG_ID);
		send_word(LEVEL1_IDS[6]);
		drain_all();
	endtask

	task automatic test_random(input int n);
		int stop;
		stop = items_sent + n;
		while (items_sent < stop) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					repeat ($urandom_range(3)) send_item(CMD_BYTE, 8'($urandom_range(255)));
					send_word(SEG_ID);
					repeat ($urandom_range(6)) send_item(CMD_BYTE, 8'($urandom_range(255)));
					if ($urandom_range(4) != 0)
						send_word(LEVEL1_IDS[$urandom_range(6)]);
					repeat ($urandom_range(4)) send_item(CMD_BYTE, 8'($urandom_range(255)));
				end
				6, 7: send_item(CMD_BYTE, 8'($urandom_range(255)));
				8: drain_steps($urandom_range(1, 5));
				default: begin
					send_item(CMD_BYTE, SEG_ID[31:24]);
					send_item(CMD_BYTE, SEG_ID[23:16]);
					send_item(CMD_BYTE, 8'($urandom_range(255)));
				end
			endcase
		end
		drain_all();
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			failed = 1;
		end
	endtask

	always @(posedge clk) begin
		seg_byte_t e;
		if (arst_n && pop && !empty) begin
			if (seg_bytes_due.size() == 0) begin
				$display("%0t: unexpected transaction: expected none, actual byte %h",
					$time, out_byte);
				failed = 1;
			end else begin
				e = seg_bytes_due.pop_front();
				check_field("out_byte", 16'(e.data), 16'(out_byte));
				check_field("is_header", 16'(e.hdr), 16'(is_header));
				check_field("segment_start", 16'(e.start), 16'(segment_start));
				check_field("segment_number", e.num, segment_number);
				check_field("last_in_run", 16'(e.last), 16'(last_in_run));
				check_field("drained", 16'(e.drn), 16'(drained));
			end
		end
	end

	always @(negedge clk)
		pop <= arst_n && ($urandom_range(99) >= pop_stall_pct);

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("matroska_segment_splitter_tb failed");
			$finish;
		end
	end

	initial begin
		line_head = 0;
		line_fill = 0;
		id_history = 0;
		l1_age = AGE_NONE;
		seg_count = 0;
		id_skip = 0;
		seg_open = 0;
		failed = 0;
		items_sent = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(24);
		send_idle_pct = 51;
		test_random(24);
		send_idle_pct = 0;
		pop_stall_pct = 51;
		test_random(24);
		send_idle_pct = 18;
		pop_stall_pct = 18;
		test_random(24);
		send_idle_pct = 0;
		pop_stall_pct = 0;
		@(negedge clk);
		push = 1'b0;
		while (seg_bytes_due.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (!failed)
			$display("matroska_segment_splitter_tb passed");
		else
			$display("matroska_segment_splitter_tb failed");
		$finish;
	end

endmodule
